// ===== hdl/ax25f_pkg.sv =====
// Shared types, constants and the CRC byte step for the AX.25 UI packet framer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ax25f_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 48;
    localparam int PHASE_W  = 6;
    localparam int CFG_IDX_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_SSID = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_SSID  = 8'd3;

    // Register reset values
    localparam logic [ADDR_W-1:0] DEST_ADDR_RST = 48'h86A2_4040_4040;
    localparam logic [ADDR_W-1:0] SRC_ADDR_RST  = 48'h9C6E_8E82_A640;
    localparam logic [BYTE_W-1:0] DEST_SSID_RST = 8'hE0;
    localparam logic [BYTE_W-1:0] SRC_SSID_RST  = 8'hE1;

    // Packet constants
    localparam logic [BYTE_W-1:0] FLAG_BYTE     = 8'h7E;
    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] CONTROL_UI    = 8'h03;
    localparam logic [BYTE_W-1:0] PID_NONE      = 8'hF0;
    localparam logic [BYTE_W-1:0] LEN_OVERHEAD  = 8'd31;
    localparam logic [15:0]       CRC_POLY      = 16'h1021;
    localparam logic [15:0]       CRC_INIT      = 16'hFFFF;

    // Packet byte positions (sequencer phases)
    localparam logic [PHASE_W-1:0] PH_PRE      = 6'd0;
    localparam logic [PHASE_W-1:0] PH_SYNC     = 6'd5;
    localparam logic [PHASE_W-1:0] PH_LEN      = 6'd6;
    localparam logic [PHASE_W-1:0] PH_FLAGS    = 6'd7;
    localparam logic [PHASE_W-1:0] PH_DEST     = 6'd16;
    localparam logic [PHASE_W-1:0] PH_DSSID    = 6'd22;
    localparam logic [PHASE_W-1:0] PH_SRC      = 6'd23;
    localparam logic [PHASE_W-1:0] PH_SSSID    = 6'd29;
    localparam logic [PHASE_W-1:0] PH_CTRL     = 6'd30;
    localparam logic [PHASE_W-1:0] PH_PID      = 6'd31;
    localparam logic [PHASE_W-1:0] PH_DATA     = 6'd32;
    localparam logic [PHASE_W-1:0] PH_ICRC_LO  = 6'd33;
    localparam logic [PHASE_W-1:0] PH_ICRC_HI  = 6'd34;
    localparam logic [PHASE_W-1:0] PH_POST     = 6'd35;
    localparam logic [PHASE_W-1:0] PH_OCRC_LO  = 6'd39;
    localparam logic [PHASE_W-1:0] PH_OCRC_HI  = 6'd40;

    // Configuration register set
    typedef struct packed {
        logic [ADDR_W-1:0] dest_address;
        logic [ADDR_W-1:0] src_address;
        logic [BYTE_W-1:0] dest_station_id;
        logic [BYTE_W-1:0] src_station_id;
    } cfg_t;

    // One held input word
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_length;
        logic              last_byte;
    } item_t;

    // Byte chosen by the sequencer for the current phase
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_end;
        logic              packet_end;
    } seq_out_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== hdl/ax25f_cfg_regs.sv =====
// Configuration register file: addresses and SSIDs of the framer.
// Depends on ax25f_pkg.
`timescale 1ns / 1ps

module ax25f_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ax25f_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ax25f_pkg::ADDR_W-1:0]   cfg_data,
    output ax25f_pkg::cfg_t                cfg_o
);
    import ax25f_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DEST_ADDR: cfg_next.dest_address    = cfg_data;
                REG_SRC_ADDR:  cfg_next.src_address     = cfg_data;
                REG_DEST_SSID: cfg_next.dest_station_id = cfg_data[BYTE_W-1:0];
                REG_SRC_SSID:  cfg_next.src_station_id  = cfg_data[BYTE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_address    <= DEST_ADDR_RST;
            cfg_reg.src_address     <= SRC_ADDR_RST;
            cfg_reg.dest_station_id <= DEST_SSID_RST;
            cfg_reg.src_station_id  <= SRC_SSID_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/ax25f_seq.sv =====
// Packet byte sequencer: phase counter, byte select and both running CRCs.
// Depends on ax25f_pkg.
`timescale 1ns / 1ps

module ax25f_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ax25f_pkg::cfg_t       cfg_i,
    input  ax25f_pkg::item_t      item_i,
    input  logic                  step,
    output ax25f_pkg::seq_out_t   seq_o
);
    import ax25f_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [15:0]        inner_crc_reg, inner_crc_next;
    logic [15:0]        outer_crc_reg, outer_crc_next;

    logic [2:0]         addr_k;
    logic [2:0]         addr_sel;
    logic [ADDR_W-1:0]  addr_word;
    logic [BYTE_W-1:0]  cur_byte;
    logic               feed_inner;
    logic               feed_outer;
    logic               run_end;
    logic               packet_end;

    // Callsign byte index, most significant byte first
    always_comb begin
        if (phase_reg < PH_SRC) begin
            addr_k    = 3'(phase_reg - PH_DEST);
            addr_word = cfg_i.dest_address;
        end else begin
            addr_k    = 3'(phase_reg - PH_SRC);
            addr_word = cfg_i.src_address;
        end
        addr_sel = 3'd5 - addr_k;
    end

    // Byte for the current phase
    always_comb begin
        if (phase_reg < PH_SYNC) begin
            cur_byte = PREAMBLE_BYTE;
        end else if (phase_reg == PH_LEN) begin
            cur_byte = item_i.payload_length + LEN_OVERHEAD;
        end else if (phase_reg < PH_DEST) begin
            cur_byte = FLAG_BYTE;
        end else if (phase_reg == PH_DSSID) begin
            cur_byte = cfg_i.dest_station_id;
        end else if (phase_reg == PH_SSSID) begin
            cur_byte = cfg_i.src_station_id;
        end else if (phase_reg < PH_CTRL) begin
            cur_byte = addr_word[{addr_sel, 3'b000} +: BYTE_W];
        end else if (phase_reg == PH_CTRL) begin
            cur_byte = CONTROL_UI;
        end else if (phase_reg == PH_PID) begin
            cur_byte = PID_NONE;
        end else if (phase_reg == PH_DATA) begin
            cur_byte = item_i.payload_byte;
        end else if (phase_reg == PH_ICRC_LO) begin
            cur_byte = inner_crc_reg[7:0];
        end else if (phase_reg == PH_ICRC_HI) begin
            cur_byte = inner_crc_reg[15:8];
        end else if (phase_reg < PH_OCRC_LO) begin
            cur_byte = FLAG_BYTE;
        end else if (phase_reg == PH_OCRC_LO) begin
            cur_byte = outer_crc_reg[7:0];
        end else begin
            cur_byte = outer_crc_reg[15:8];
        end
    end

    // CRC coverage windows
    assign feed_inner = (phase_reg >= PH_DEST) && (phase_reg <= PH_DATA);
    assign feed_outer = (phase_reg >= PH_LEN) && (phase_reg < PH_OCRC_LO);

    assign packet_end = (phase_reg == PH_OCRC_HI);
    assign run_end    = packet_end || ((phase_reg == PH_DATA) && !item_i.last_byte);

    assign seq_o.out_byte   = cur_byte;
    assign seq_o.run_end    = run_end;
    assign seq_o.packet_end = packet_end;

    // Phase advance: mid-frame words start at the data phase
    always_comb begin
        phase_next     = phase_reg;
        inner_crc_next = inner_crc_reg;
        outer_crc_next = outer_crc_reg;
        if (step) begin
            if (packet_end) begin
                phase_next = PH_PRE;
            end else if (run_end) begin
                phase_next = PH_DATA;
            end else begin
                phase_next = phase_reg + 6'd1;
            end
            if (phase_reg == PH_PRE) begin
                inner_crc_next = CRC_INIT;
                outer_crc_next = CRC_INIT;
            end else begin
                if (feed_inner) begin
                    inner_crc_next = crc16_byte(inner_crc_reg, cur_byte);
                end
                if (feed_outer) begin
                    outer_crc_next = crc16_byte(outer_crc_reg, cur_byte);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_PRE;
            inner_crc_reg <= CRC_INIT;
            outer_crc_reg <= CRC_INIT;
        end else begin
            phase_reg     <= phase_next;
            inner_crc_reg <= inner_crc_next;
            outer_crc_reg <= outer_crc_next;
        end
    end

    // Phase never runs past the last trailer byte
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_OCRC_HI)
        else $error("sequencer phase out of range");

    // A finished packet returns the sequencer to the preamble
    a_packet_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        step && packet_end |=> phase_reg == PH_PRE)
        else $error("sequencer did not wrap after packet end");

    // Both CRCs start fresh once the first preamble byte is out
    a_crc_init: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (phase_reg == PH_PRE)
        |=> (inner_crc_reg == CRC_INIT) && (outer_crc_reg == CRC_INIT))
        else $error("CRC not initialized at frame start");

endmodule

// ===== hdl/ax25_radio_packet_framer_unit.sv =====
// Top level of the AX.25 UI radio packet framer: input holding register,
// output register, sequencer and config registers. Depends on ax25f_pkg.
//
//  channel | dir | handshake              | content
//  s_      | in  | s_tvalid / s_tready    | payload word, tlast = final payload byte
//  m_      | out | m_tvalid / m_tready    | packet byte, tlast = packet end
//  cfg_    | in  | cfg_valid / cfg_ready  | register index and write data
//
// One packet byte leaves per cycle unless the output stalls or no word is held.
// A mid-frame word yields its data byte only, the first word of a frame also the
// header, the last word also the trailer; the byte sequencer sets these runs.
// A new word is taken in the cycle its predecessor emits its final byte.
// Reset is synchronous; it idles the block between frames and loads the
// default addresses. Output stalls hold the sequencer and, in turn, the input.
`timescale 1ns / 1ps

module ax25_radio_packet_framer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // payload_byte, payload_length
    input  logic                            s_tlast,   // last_byte
    // packet bytes
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // out_byte
    output logic                            m_tlast,   // packet_end
    output logic                            m_tuser,   // run_end
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ax25f_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ax25f_pkg::ADDR_W-1:0]    cfg_data
);
    import ax25f_pkg::*;

    cfg_t      cfg;
    seq_out_t  seq_o;

    item_t              hold_reg, hold_next;
    logic               hold_valid_reg, hold_valid_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_run_reg, out_run_next;
    logic               out_pkt_reg, out_pkt_next;

    logic               out_load;
    logic               hold_done;
    logic               s_accept;

    ax25f_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    ax25f_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_i   (cfg),
        .item_i  (hold_reg),
        .step    (out_load),
        .seq_o   (seq_o)
    );

    // Handshake control
    assign out_load  = hold_valid_reg && (!m_tvalid_reg || m_tready);
    assign hold_done = out_load && seq_o.run_end;
    assign s_tready  = !hold_valid_reg || hold_done;
    assign s_accept  = s_tvalid && s_tready;

    // Input holding register
    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (s_accept) begin
            hold_next.payload_byte   = s_tdata[7:0];
            hold_next.payload_length = s_tdata[15:8];
            hold_next.last_byte      = s_tlast;
            hold_valid_next          = 1'b1;
        end else if (hold_done) begin
            hold_valid_next = 1'b0;
        end
    end

    // Output register
    always_comb begin
        out_byte_next = out_byte_reg;
        out_run_next  = out_run_reg;
        out_pkt_next  = out_pkt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            out_byte_next = seq_o.out_byte;
            out_run_next  = seq_o.run_end;
            out_pkt_next  = seq_o.packet_end;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg     <= hold_next;
        out_byte_reg <= out_byte_next;
        out_run_reg  <= out_run_next;
        out_pkt_reg  <= out_pkt_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_pkt_reg;
    assign m_tuser  = out_run_reg;

    // The packet's final byte always closes its word's run
    a_pkt_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_pkt_reg |-> out_run_reg)
        else $error("packet end without run end");

endmodule
